// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the canonical k-mer extractor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/cke_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canonical k-mer extractor package
// Widths, register indexes, the decoded item type and the helper functions
// shared by the extractor modules.
// ----------------------------------------------------------------------------
package cke_pkg;

  localparam int MAX_K  = 28;
  localparam int WORD_W = 2 * MAX_K;
  localparam int CNT_W  = 5;
  localparam int CHAR_W = 8;

  localparam logic [CNT_W-1:0] K_RESET = CNT_W'(15);
  localparam logic [CNT_W-1:0] K_MAX   = CNT_W'(MAX_K);

  // Configuration register indexes.
  localparam logic REG_KMER_LENGTH = 1'b0;
  localparam logic REG_HPC_ENABLE  = 1'b1;

  // Base codes.
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  // One character after decoding, as held in the input register.
  typedef struct packed {
    logic       last;
    logic       amb;
    logic [1:0] code;
  } cke_item_t;

  // Maps a character byte to a base code; anything unknown is ambiguous.
  function automatic cke_item_t base_decode(input logic [CHAR_W-1:0] ch,
                                            input logic last);
    cke_item_t it;
    it.last = last;
    it.amb  = 1'b0;
    it.code = BASE_A;
    case (ch)
      8'h00, 8'h41, 8'h61:               it.code = BASE_A;
      8'h01, 8'h43, 8'h63:               it.code = BASE_C;
      8'h02, 8'h47, 8'h67:               it.code = BASE_G;
      8'h03, 8'h54, 8'h74, 8'h55, 8'h75: it.code = BASE_T;
      default:                           it.amb  = 1'b1;
    endcase
    return it;
  endfunction

  // Clamps k into the supported range 1 .. MAX_K.
  function automatic logic [CNT_W-1:0] k_clamp(input logic [CNT_W-1:0] k);
    logic [CNT_W-1:0] r;
    r = k;
    if (k == '0) r = CNT_W'(1);
    if (k > K_MAX) r = K_MAX;
    return r;
  endfunction

  // Mask of the low 2k bits of a k-mer word.
  function automatic logic [WORD_W-1:0] k_mask(input logic [CNT_W-1:0] k);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_K; i++) begin
      m[2*i +: 2] = (CNT_W'(i) < k) ? 2'b11 : 2'b00;
    end
    return m;
  endfunction

  // Mask of the base slot that receives the newest complement, bits 2k-1:2k-2.
  function automatic logic [WORD_W-1:0] k_top(input logic [CNT_W-1:0] k);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_K; i++) begin
      m[2*i +: 2] = (CNT_W'(i + 1) == k) ? 2'b11 : 2'b00;
    end
    return m;
  endfunction

endpackage

// ===== rtl/cke_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input stage
// Decodes the incoming character and holds it in the input register until
// the core takes it.
// ----------------------------------------------------------------------------
module cke_in_stage
  import cke_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,
  input  logic              in_tlast,
  input  logic              advance,
  output logic              s1_valid,
  output cke_item_t         s1_item
);

  logic      valid_r;
  logic      valid_nxt;
  cke_item_t item_r;

  // The register can load when it is empty or being drained this cycle.
  assign in_tready = !valid_r || advance;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture on every accepted transaction.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= base_decode(in_tdata, in_tlast);
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== rtl/cke_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// K-mer core
// Configuration registers, k-mer state update, canonical selection and the
// result register.
// ----------------------------------------------------------------------------
module cke_core
  import cke_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              s1_valid,
  input  cke_item_t         s1_item,
  output logic              advance,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WORD_W-1:0] out_kmer,
  output logic              out_rev
);

  // Configuration and derived masks.
  logic              hpc_r;
  logic [CNT_W-1:0]  k_eff_r;
  logic [WORD_W-1:0] mask_r;
  logic [WORD_W-1:0] top_r;

  // K-mer state.
  logic [WORD_W-1:0] fwd_r, fwd_nxt;
  logic [WORD_W-1:0] rev_r, rev_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        prev_base_r, prev_base_nxt;
  logic              prev_valid_r, prev_valid_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_kmer_r;
  logic              out_rev_r;

  logic              proc;
  logic              drop;
  logic [1:0]        comp;
  logic [WORD_W-1:0] fwd_sh;
  logic [WORD_W-1:0] rev_sh;
  logic              sym;
  logic              rev_sel;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  cnt_sat;
  logic              emit;

  // Configuration writes; k is clamped once here and the masks follow it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hpc_r         <= 1'b0;
      k_eff_r       <= k_clamp(K_RESET);
      mask_r        <= k_mask(k_clamp(K_RESET));
      top_r         <= k_top(k_clamp(K_RESET));
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KMER_LENGTH: begin
          k_eff_r       <= k_clamp(cfg_data);
          mask_r        <= k_mask(k_clamp(cfg_data));
          top_r         <= k_top(k_clamp(cfg_data));
        end
        REG_HPC_ENABLE: begin
          hpc_r <= cfg_data[0];
        end
        default: begin
          hpc_r <= hpc_r;
        end
      endcase
    end
  end

  // The item advances when the result register is free or being drained.
  assign advance = !out_valid_r || out_tready;
  assign proc    = s1_valid && advance;

  // Shift the new base into both words.
  assign comp   = ~s1_item.code;
  assign drop   = hpc_r && prev_valid_r && (prev_base_r == s1_item.code);
  assign fwd_sh = {fwd_r[WORD_W-3:0], s1_item.code} & mask_r;
  assign rev_sh = ((rev_r >> 2) | (top_r & {MAX_K{comp}})) & mask_r;
  assign sym     = (fwd_sh == rev_sh);
  assign rev_sel = !(fwd_sh < rev_sh);

  // Count of valid bases, saturating at k.
  assign cnt_inc = (cnt_r < k_eff_r) ? cnt_r + CNT_W'(1) : cnt_r;
  assign cnt_sat = (cnt_inc > k_eff_r) ? k_eff_r : cnt_inc;
  assign emit    = !s1_item.amb && !drop && !sym && (cnt_sat >= k_eff_r);

  // Next state of the k-mer words and counters.
  always_comb begin
    fwd_nxt        = fwd_r;
    rev_nxt        = rev_r;
    cnt_nxt        = cnt_r;
    prev_base_nxt  = prev_base_r;
    prev_valid_nxt = prev_valid_r;
    if (proc) begin
      if (s1_item.amb) begin
        cnt_nxt        = '0;
        prev_valid_nxt = 1'b0;
      end else if (!drop) begin
        fwd_nxt        = fwd_sh;
        rev_nxt        = rev_sh;
        prev_base_nxt  = s1_item.code;
        prev_valid_nxt = 1'b1;
        if (!sym) begin
          cnt_nxt = cnt_sat;
        end
      end
      if (s1_item.last) begin
        fwd_nxt        = '0;
        rev_nxt        = '0;
        cnt_nxt        = '0;
        prev_base_nxt  = BASE_A;
        prev_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r        <= '0;
      rev_r        <= '0;
      cnt_r        <= '0;
      prev_base_r  <= BASE_A;
      prev_valid_r <= 1'b0;
    end else begin
      fwd_r        <= fwd_nxt;
      rev_r        <= rev_nxt;
      cnt_r        <= cnt_nxt;
      prev_base_r  <= prev_base_nxt;
      prev_valid_r <= prev_valid_nxt;
    end
  end

  // Result register.
  assign out_valid_nxt = advance ? (proc && emit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      out_kmer_r <= rev_sel ? rev_sh : fwd_sh;
      out_rev_r  <= rev_sel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_kmer   = out_kmer_r;
  assign out_rev    = out_rev_r;

  // Checks on the core logic.
  `ASSERT_PROP(a_last_clears, clk, rst_n,
    proc && s1_item.last |=> (cnt_r == '0 && !prev_valid_r && fwd_r == '0 && rev_r == '0),
    "state not cleared after the last character of a sequence")
  `ASSERT_PROP(a_emit_at_k, clk, rst_n, proc && emit |-> cnt_sat == k_eff_r,
    "result emitted before the base count reached k")
  `ASSERT_PROP(a_ambig_resets, clk, rst_n, proc && s1_item.amb |=> cnt_r == '0,
    "ambiguous character did not reset the base count")
  `ASSERT_PROP(a_kmer_masked, clk, rst_n,
    proc && emit |=> (out_kmer_r & ~$past(mask_r)) == '0,
    "emitted k-mer has bits beyond 2k")

endmodule

// ===== rtl/canonical_kmer_extractor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canonical k-mer extractor
// Streams sequence characters and emits the canonical 2-bit k-mer at each
// position once k valid bases are in the window.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while the output side does not
// stall. An accepted character is held and decoded in the input register, then
// goes through the k-mer update, and its result is registered in the result
// register. The k-mer words and the base count are updated once per
// character, so characters follow back to back without gaps. While a
// result waits in the result register with out_tready low, the input
// register still takes one more character; after that in_tready drops until
// the result is taken. Characters that give no result (ambiguous bases,
// collapsed homopolymer bases, symmetric k-mers, bases before k) never wait
// for the output side once the result register is free. Configuration writes
// are taken in every cycle and are meant to be made while the block is idle.
module canonical_kmer_extractor_unit
  import cke_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Configuration write channel.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CNT_W-1:0]  cfg_data,
  // Character input.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,   // [7:0] base_char
  input  logic              in_tlast,   // seq_last
  // Result output.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WORD_W-1:0] out_tdata,  // [55:0] canonical_kmer
  output logic              out_tuser   // [0] reverse_strand
);

  logic      advance;
  logic      s1_valid;
  cke_item_t s1_item;

  assign cfg_ready = 1'b1;

  cke_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item)
  );

  cke_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_kmer   (out_tdata),
    .out_rev    (out_tuser)
  );

endmodule
